// ===== hdl/hrhp_pkg.sv =====
package hrhp_pkg;

  // Width of byte positions within one request
  localparam int unsigned OFS_W = 16;
  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

  // Header limit register
  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8192;

  // APB register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_HEADER_LIMIT = 1'b0;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Byte roles
  localparam logic [3:0] ROLE_METHOD     = 4'd0;
  localparam logic [3:0] ROLE_FIRST_SP   = 4'd1;
  localparam logic [3:0] ROLE_TARGET     = 4'd2;
  localparam logic [3:0] ROLE_NAME       = 4'd3;
  localparam logic [3:0] ROLE_COLON      = 4'd4;
  localparam logic [3:0] ROLE_SKIP_SP    = 4'd5;
  localparam logic [3:0] ROLE_VALUE      = 4'd6;
  localparam logic [3:0] ROLE_CRLF       = 4'd7;
  localparam logic [3:0] ROLE_HEADER_END = 4'd8;
  localparam logic [3:0] ROLE_BODY       = 4'd9;
  localparam logic [3:0] ROLE_DISCARD    = 4'd10;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LIMIT     = 3'd1;
  localparam logic [2:0] ST_LONE_CR   = 3'd2;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
  localparam logic [2:0] ST_BAD_RLINE = 3'd4;
  localparam logic [2:0] ST_PATH      = 3'd5;
  localparam logic [2:0] ST_NO_COLON  = 3'd6;

  // One tagged byte
  typedef struct packed {
    logic [7:0]       byte_out;
    logic [3:0]       role;
    logic [OFS_W-1:0] offset;
    logic [OFS_W-1:0] protocol_offset;
    logic             line_end;
    logic [2:0]       status;
    logic             header_done;
  } result_t;

endpackage

// ===== hdl/hrhp_cfg_regs.sv =====
module hrhp_cfg_regs
  import hrhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [LIMIT_W-1:0] header_limit_o
);

  logic [LIMIT_W-1:0] header_limit_q;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign wr_en   = psel & penable & pwrite & (reg_idx == REG_HEADER_LIMIT);

  // Hold the header limit; update on a completed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      header_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Read back; unmapped addresses read as zero
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_HEADER_LIMIT) begin
      prdata = {{(APB_DW-LIMIT_W){1'b0}}, header_limit_q};
    end
  end

  assign header_limit_o = header_limit_q;

endmodule

// ===== hdl/hrhp_parser.sv =====
module hrhp_parser
  import hrhp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic               start_request_i,
  input  logic [LIMIT_W-1:0] header_limit_i,
  output result_t            res_o
);

  typedef enum logic [1:0] {
    PH_REQ,
    PH_HDR,
    PH_BODY,
    PH_ERR
  } phase_e;

  phase_e           phase_q, phase_d, ph;
  logic [OFS_W-1:0] cnt_q, cnt_d, pos;
  logic [OFS_W-1:0] fsp_at_q, fsp_at_d, lsp_at_q, lsp_at_d;
  logic             cr_q, cr_d, nl_q, nl_d;
  logic             fsp_q, fsp_d, ssp_q, ssp_d;
  logic             slash_q, slash_d, colon_q, colon_d, val_q, val_d;
  logic [7:0]       b;
  result_t          res;

  assign b = data_byte_i;

  // Classify the byte against the current parse state
  always_comb begin
    ph       = phase_q;
    pos      = cnt_q;
    cr_d     = cr_q;
    nl_d     = nl_q;
    fsp_at_d = fsp_at_q;
    fsp_d    = fsp_q;
    lsp_at_d = lsp_at_q;
    ssp_d    = ssp_q;
    slash_d  = slash_q;
    colon_d  = colon_q;
    val_d    = val_q;
    // start of a new request clears the parse state before this byte
    if (start_request_i) begin
      ph       = PH_REQ;
      pos      = '0;
      cr_d     = 1'b0;
      nl_d     = 1'b0;
      fsp_at_d = '0;
      fsp_d    = 1'b0;
      lsp_at_d = '0;
      ssp_d    = 1'b0;
      slash_d  = 1'b0;
      colon_d  = 1'b0;
      val_d    = 1'b0;
    end
    phase_d = ph;
    cnt_d   = (pos == OFS_MAX) ? pos : pos + OFS_W'(1);

    res                 = '0;
    res.byte_out        = b;
    res.offset          = pos;
    res.role            = ROLE_DISCARD;
    res.status          = ST_OK;

    case (ph)
      PH_BODY: begin
        res.role = ROLE_BODY;
      end
      PH_REQ, PH_HDR: begin
        if ((pos >= header_limit_i) || (pos == OFS_MAX)) begin
          res.status = ST_LIMIT;
        end else if (cr_d && (b != CH_LF)) begin
          res.status = ST_LONE_CR;
        end else if (b == CH_CR) begin
          cr_d     = 1'b1;
          res.role = ROLE_CRLF;
        end else if (b == CH_LF) begin
          cr_d     = 1'b0;
          res.role = ROLE_CRLF;
          if (nl_d) begin
            // blank line ends the header
            res.role        = ROLE_HEADER_END;
            res.header_done = 1'b1;
            phase_d         = PH_BODY;
          end else if (ph == PH_REQ) begin
            nl_d = 1'b1;
            if (!fsp_d || !ssp_d) begin
              res.status = ST_BAD_RLINE;
            end else if (!slash_d) begin
              res.status = ST_PATH;
            end else begin
              res.line_end        = 1'b1;
              res.protocol_offset = lsp_at_d + OFS_W'(1);
              phase_d             = PH_HDR;
            end
          end else begin
            nl_d = 1'b1;
            if (!colon_d) begin
              res.status = ST_NO_COLON;
            end else begin
              res.line_end = 1'b1;
              colon_d      = 1'b0;
              val_d        = 1'b0;
            end
          end
        end else if (!(b inside {[CH_SP:CH_TILDE]})) begin
          res.status = ST_BAD_CHAR;
        end else begin
          nl_d = 1'b0;
          if (ph == PH_REQ) begin
            if (!fsp_d) begin
              if (b == CH_SP) begin
                fsp_d    = 1'b1;
                fsp_at_d = pos;
                res.role = ROLE_FIRST_SP;
              end else begin
                res.role = ROLE_METHOD;
              end
            end else begin
              res.role = ROLE_TARGET;
              if ((pos == fsp_at_d + OFS_W'(1)) && (b == CH_SLASH)) begin
                slash_d = 1'b1;
              end
              if (b == CH_SP) begin
                ssp_d    = 1'b1;
                lsp_at_d = pos;
              end
            end
          end else if (!colon_d) begin
            if (b == CH_COLON) begin
              colon_d  = 1'b1;
              res.role = ROLE_COLON;
            end else begin
              res.role = ROLE_NAME;
            end
          end else if (!val_d && (b == CH_SP)) begin
            res.role = ROLE_SKIP_SP;
          end else begin
            val_d    = 1'b1;
            res.role = ROLE_VALUE;
          end
        end
        // any error ends parsing until the next request
        if (res.status != ST_OK) begin
          phase_d             = PH_ERR;
          res.role            = ROLE_DISCARD;
          res.header_done     = 1'b1;
          res.protocol_offset = '0;
          res.line_end        = 1'b0;
        end
      end
      default: begin
        res.role = ROLE_DISCARD;
      end
    endcase
  end

  // Hold parse state; advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_REQ;
      cnt_q    <= '0;
      cr_q     <= 1'b0;
      nl_q     <= 1'b0;
      fsp_at_q <= '0;
      fsp_q    <= 1'b0;
      lsp_at_q <= '0;
      ssp_q    <= 1'b0;
      slash_q  <= 1'b0;
      colon_q  <= 1'b0;
      val_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      cr_q     <= cr_d;
      nl_q     <= nl_d;
      fsp_at_q <= fsp_at_d;
      fsp_q    <= fsp_d;
      lsp_at_q <= lsp_at_d;
      ssp_q    <= ssp_d;
      slash_q  <= slash_d;
      colon_q  <= colon_d;
      val_q    <= val_d;
    end
  end

  assign res_o = res;

  // An error byte always ends the header and is discarded
  a_err_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res.status != ST_OK)) |-> (res.header_done && (res.role == ROLE_DISCARD)))
    else $error("error byte not flagged as done/discarded");

  // A completed line always leaves the parser in the header lines
  a_line_hdr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.line_end) |=> (phase_q == PH_HDR))
    else $error("line end did not move parser to header lines");

  // Once in the body, bytes stay body until a new request
  a_body : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !start_request_i && (phase_q == PH_BODY)) |-> (res.role == ROLE_BODY))
    else $error("body byte tagged wrongly");

  // Position never moves backwards within a request
  a_cnt_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !start_request_i) |=> (cnt_q >= $past(cnt_q)))
    else $error("byte position went backwards");

endmodule

// ===== hdl/hrhp_out_reg.sv =====
module hrhp_out_reg
  import hrhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    busy_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Refuse a new request only while a held result is stalled
  assign busy_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q & out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  // Hold valid; drop it once the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the tagged byte
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/http_request_header_parser.sv =====
// HTTP request header parser: takes one request byte per cycle on the input
// channel and returns the same byte in the next cycle, tagged with its role,
// its position in the request and any error status. Throughput is one byte
// per clock while the input is not stalled, set by the update of the parse
// state on each accepted byte. The input stalls only while a finished result
// is held by a stall on the output. Assert start_request_i with the first
// byte of every request. header_limit (APB address 0, reset 8192) bounds the
// header length; write it only while the block is idle.
module http_request_header_parser
  import hrhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Byte input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_request_i,
  // Tagged byte output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        byte_out_o,
  output logic [3:0]        role_o,
  output logic [OFS_W-1:0]  offset_o,
  output logic [OFS_W-1:0]  protocol_offset_o,
  output logic              line_end_o,
  output logic [2:0]        status_o,
  output logic              header_done_o
);

  logic [LIMIT_W-1:0] header_limit;
  logic               step;
  logic               busy;
  result_t            res_comb;
  result_t            res_out;

  hrhp_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .header_limit_o (header_limit)
  );

  // Accept a request whenever the output side has room
  assign in_stall_o = busy;
  assign step       = in_valid_i & ~busy;

  hrhp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .data_byte_i     (data_byte_i),
    .start_request_i (start_request_i),
    .header_limit_i  (header_limit),
    .res_o           (res_comb)
  );

  hrhp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_comb),
    .out_stall_i (out_stall_i),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign byte_out_o        = res_out.byte_out;
  assign role_o            = res_out.role;
  assign offset_o          = res_out.offset;
  assign protocol_offset_o = res_out.protocol_offset;
  assign line_end_o        = res_out.line_end;
  assign status_o          = res_out.status;
  assign header_done_o     = res_out.header_done;

endmodule
